// ===== rtl/core/mwd_pkg.sv =====
// ----------------------------------------------------------------------------
// mwd_pkg: shared types and constants of the 3x3 median denoise block
// Pixel packing, window columns, line-store entry and register indexes.
// ----------------------------------------------------------------------------
package mwd_pkg;

  localparam int MaxWidth = 1024;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int RowW     = 11;
  localparam int CfgW     = 11;
  localparam int IdxW     = 2;

  // Register indexes on the configuration port
  localparam logic [IdxW-1:0] RegColorMode   = 2'd0;
  localparam logic [IdxW-1:0] RegFrameWidth  = 2'd1;
  localparam logic [IdxW-1:0] RegFrameHeight = 2'd2;

  // Input commands
  localparam logic CmdPixel = 1'b0;
  localparam logic CmdFlush = 1'b1;

  // {red, green, blue}; in gray mode the sample sits in the low byte
  typedef logic [23:0] pix_t;

  // One window column, three rows
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } column_t;

  // Index 0 is the left column, 2 the right one
  typedef column_t [2:0] window_t;

  // Line-store entry: the two most recent rows at one column
  typedef struct packed {
    pix_t prev1;
    pix_t prev2;
  } line_t;

endpackage

// ===== rtl/core/mwd_median.sv =====
// ----------------------------------------------------------------------------
// mwd_median: per-channel median of a 3x3 window
// Three 19-exchange sorting networks, one for each byte of the packed pixel.
// ----------------------------------------------------------------------------
module mwd_median (
  input  mwd_pkg::window_t win,
  output mwd_pkg::pix_t    med
);

  localparam int Exch = 19;

  // Compare-exchange pairs of the optimal 9-input median network
  localparam logic [3:0] SortLo [Exch] = '{
    4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd0,
    4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4
  };
  localparam logic [3:0] SortHi [Exch] = '{
    4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8, 4'd3,
    4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2
  };

  function automatic logic [7:0] median9(input logic [8:0][7:0] v);
    logic [8:0][7:0] p;
    logic [7:0]      t;
    p = v;
    for (int k = 0; k < Exch; k++) begin
      if (p[SortLo[k]] > p[SortHi[k]]) begin
        t             = p[SortLo[k]];
        p[SortLo[k]]  = p[SortHi[k]];
        p[SortHi[k]]  = t;
      end
    end
    return p[4];
  endfunction

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    logic [8:0][7:0] taps;

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        taps[3*j]     = win[j].top[8*ch +: 8];
        taps[3*j + 1] = win[j].mid[8*ch +: 8];
        taps[3*j + 2] = win[j].bot[8*ch +: 8];
      end
    end

    assign med[8*ch +: 8] = median9(taps);
  end

endmodule

// ===== rtl/core/median_window_denoise_top.sv =====
// ----------------------------------------------------------------------------
// median_window_denoise_top: streaming 3x3 median filter
// Raster-order pixels in, one median result per pixel position out, with
// replicated borders, gray or per-channel RGB operation.
// ----------------------------------------------------------------------------
// The block accepts one request per clock while in_stall is low and returns,
// for each pixel position, the median of its 3x3 neighborhood; samples
// outside the frame repeat the nearest edge sample. Results trail the input
// by one row and one column: a pixel at row i, column c (i >= 1, c >= 1)
// yields the result for row i-1, column c-1, and the last pixel of a row also
// yields the result for the last column, so that request gives two results
// and in_stall stays high until the second is taken. Row 0 and column 0
// pixels yield nothing (but a width-1 row end). Once the frame's last pixel
// is in, send flush requests (in_cmd = 1): each one returns one result of
// the bottom row, and the final one carries out_frame_last. A flush outside
// this phase is dropped; a pixel during it starts a new frame. Sustained
// rate is one request per cycle but for row ends and stalls, set by the
// single-write-port line store (1024 x 48 bits, registered read) and the
// one-result-per-cycle output register. A register write restarts the frame.
// Widths of 0 act as 1 and above 1024 as 1024; a height of 0 acts as 1.
// ----------------------------------------------------------------------------
module median_window_denoise_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_we,
  input  logic [mwd_pkg::IdxW-1:0]    cfg_index,
  input  logic [mwd_pkg::CfgW-1:0]    cfg_wdata,
  // input requests
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_cmd,
  input  logic [7:0]                  in_gray_in,
  input  logic [7:0]                  in_red_in,
  input  logic [7:0]                  in_green_in,
  input  logic [7:0]                  in_blue_in,
  // results
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_gray_out,
  output logic [7:0]                  out_red_out,
  output logic [7:0]                  out_green_out,
  output logic [7:0]                  out_blue_out,
  output logic                        out_frame_last
);

  // --------------------------------------------------------------------------
  // Configuration: store width-1 and height-1 already clamped
  // --------------------------------------------------------------------------
  logic                       color_mode_r;
  logic [mwd_pkg::ColW-1:0]   wm1_r;
  logic [mwd_pkg::RowW-1:0]   hm1_r;
  logic [mwd_pkg::ColW-1:0]   cfg_wm1;
  logic [mwd_pkg::RowW-1:0]   cfg_hm1;
  logic                       cfg_hit;

  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_wm1 = '0;
    end else if (cfg_wdata > mwd_pkg::CfgW'(mwd_pkg::MaxWidth)) begin
      cfg_wm1 = mwd_pkg::ColW'(mwd_pkg::MaxWidth - 1);
    end else begin
      cfg_wm1 = mwd_pkg::ColW'(cfg_wdata - 1'b1);
    end
    cfg_hm1 = (cfg_wdata == '0) ? '0 : mwd_pkg::RowW'(cfg_wdata - 1'b1);
  end

  assign cfg_hit = cfg_we && (cfg_index == mwd_pkg::RegColorMode ||
                              cfg_index == mwd_pkg::RegFrameWidth ||
                              cfg_index == mwd_pkg::RegFrameHeight);

  // --------------------------------------------------------------------------
  // Stage 0: position bookkeeping at accept time
  // --------------------------------------------------------------------------
  logic [mwd_pkg::ColW-1:0]   col_r, col_nxt;
  logic [mwd_pkg::RowW-1:0]   row_r, row_nxt;
  logic                       frame_full_r, full_nxt;

  logic                       in_take;
  logic                       is_flush;
  logic [mwd_pkg::ColW-1:0]   c0;
  logic [mwd_pkg::RowW-1:0]   i0;
  logic                       row_end;
  logic                       flush_last;
  logic                       s1_load;
  logic [mwd_pkg::ColW-1:0]   rd_addr_a;
  logic [mwd_pkg::ColW-1:0]   rd_addr_b;

  assign in_take    = in_valid && !in_stall;
  assign is_flush   = (in_cmd == mwd_pkg::CmdFlush);
  // a pixel in the flush phase opens a new frame
  assign c0         = frame_full_r ? '0 : col_r;
  assign i0         = frame_full_r ? '0 : row_r;
  assign row_end    = (c0 == wm1_r);
  // in the flush phase col_r walks the bottom row
  assign flush_last = (col_r == wm1_r);
  assign s1_load    = in_take && (!is_flush || frame_full_r);
  assign rd_addr_a  = is_flush ? col_r : c0;
  // right neighbor of a flush column, clamped at the row end
  assign rd_addr_b  = flush_last ? col_r : mwd_pkg::ColW'(col_r + 1'b1);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    full_nxt = frame_full_r;
    if (cfg_hit) begin
      col_nxt  = '0;
      row_nxt  = '0;
      full_nxt = 1'b0;
    end else if (in_take) begin
      if (is_flush) begin
        if (frame_full_r) begin
          if (flush_last) begin
            col_nxt  = '0;
            full_nxt = 1'b0;
          end else begin
            col_nxt = mwd_pkg::ColW'(col_r + 1'b1);
          end
        end
      end else begin
        full_nxt = 1'b0;
        row_nxt  = i0;
        if (row_end) begin
          col_nxt = '0;
          if (i0 == hm1_r) begin
            row_nxt  = '0;
            full_nxt = 1'b1;
          end else begin
            row_nxt = mwd_pkg::RowW'(i0 + 1'b1);
          end
        end else begin
          col_nxt = mwd_pkg::ColW'(c0 + 1'b1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 register: the request with its line-store read
  // --------------------------------------------------------------------------
  logic                       s1_valid_r;
  logic                       s1_flush_r;
  logic                       s1_emit_a_r;   // result for column c-1 (or flush)
  logic                       s1_emit_b_r;   // extra result for the row end
  logic                       s1_left_edge_r;
  logic                       s1_col_zero_r;
  logic                       s1_top_dup_r;
  logic                       s1_last_r;
  logic [mwd_pkg::ColW-1:0]   s1_col_r;
  mwd_pkg::pix_t              s1_pix_r;

  logic                       s1_busy_emit;
  logic                       out_free;
  logic                       emit_go;
  logic                       s1_retire;

  assign s1_busy_emit = s1_emit_a_r || s1_emit_b_r;
  assign out_free     = !out_valid || !out_stall;
  assign emit_go      = s1_valid_r && s1_busy_emit && out_free;
  // leave once the last pending result moves into the output register
  assign s1_retire    = s1_valid_r &&
                        (!s1_busy_emit || (out_free && !(s1_emit_a_r && s1_emit_b_r)));
  assign in_stall     = s1_valid_r && !s1_retire;

  // --------------------------------------------------------------------------
  // Line store: entry c holds rows i-1 and i-2 at column c
  // --------------------------------------------------------------------------
  mwd_pkg::line_t             line_mem [mwd_pkg::MaxWidth];
  mwd_pkg::line_t             rd_a_raw_r, rd_b_raw_r;
  mwd_pkg::line_t             wr_hold_r;
  logic                       fwd_a_r, fwd_b_r;
  mwd_pkg::line_t             rd_a, rd_b;
  mwd_pkg::line_t             wr_data;
  logic                       mem_we;

  assign mem_we  = s1_retire && !s1_flush_r;
  assign wr_data = '{prev1: s1_pix_r, prev2: rd_a.prev1};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[s1_col_r] <= wr_data;
    end
    if (s1_load) begin
      rd_a_raw_r <= line_mem[rd_addr_a];
      rd_b_raw_r <= line_mem[rd_addr_b];
    end
  end

  // Forward the entry written at the same edge (narrow frames revisit it)
  always_ff @(posedge clk) begin
    if (s1_load) begin
      wr_hold_r <= wr_data;
      fwd_a_r   <= mem_we && (s1_col_r == rd_addr_a);
      fwd_b_r   <= mem_we && (s1_col_r == rd_addr_b);
    end
  end

  assign rd_a = fwd_a_r ? wr_hold_r : rd_a_raw_r;
  assign rd_b = fwd_b_r ? wr_hold_r : rd_b_raw_r;

  // --------------------------------------------------------------------------
  // Window columns and column history
  // --------------------------------------------------------------------------
  mwd_pkg::column_t           col_a_r, col_b_r;  // columns c-2 and c-1
  mwd_pkg::column_t           col_c, col_d;
  mwd_pkg::window_t           win;
  mwd_pkg::pix_t              med;

  always_comb begin
    col_c.top = s1_top_dup_r ? rd_a.prev1 : rd_a.prev2;
    col_c.mid = rd_a.prev1;
    col_c.bot = s1_flush_r ? rd_a.prev1 : s1_pix_r;
    // flush: bottom row replicates downward
    col_d.top = s1_top_dup_r ? rd_b.prev1 : rd_b.prev2;
    col_d.mid = rd_b.prev1;
    col_d.bot = rd_b.prev1;

    if (s1_flush_r) begin
      win[0] = s1_left_edge_r ? col_c : col_b_r;
      win[1] = col_c;
      win[2] = col_d;
    end else if (s1_emit_a_r) begin
      win[0] = s1_left_edge_r ? col_b_r : col_a_r;
      win[1] = col_b_r;
      win[2] = col_c;
    end else begin
      // row end: right edge replicates
      win[0] = s1_col_zero_r ? col_c : col_b_r;
      win[1] = col_c;
      win[2] = col_c;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_retire) begin
      if (!s1_flush_r) begin
        col_a_r <= col_b_r;
      end
      col_b_r <= col_c;
    end
  end

  mwd_median u_median (
    .win (win),
    .med (med)
  );

  // --------------------------------------------------------------------------
  // Stage 1 payload
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_flush_r     <= is_flush;
      s1_left_edge_r <= is_flush ? (col_r == '0) : (c0 == mwd_pkg::ColW'(1));
      s1_col_zero_r  <= (c0 == '0);
      s1_top_dup_r   <= is_flush ? (hm1_r == '0) : (i0 == mwd_pkg::RowW'(1));
      s1_last_r      <= is_flush && flush_last;
      s1_col_r       <= c0;
      s1_pix_r       <= color_mode_r ? {in_red_in, in_green_in, in_blue_in}
                                     : {16'd0, in_gray_in};
    end
  end

  // --------------------------------------------------------------------------
  // Control registers and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= 1'b0;
      wm1_r        <= mwd_pkg::ColW'(255);
      hm1_r        <= mwd_pkg::RowW'(255);
      col_r        <= '0;
      row_r        <= '0;
      frame_full_r <= 1'b0;
      s1_valid_r   <= 1'b0;
      s1_emit_a_r  <= 1'b0;
      s1_emit_b_r  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mwd_pkg::RegColorMode:   color_mode_r <= cfg_wdata[0];
          mwd_pkg::RegFrameWidth:  wm1_r        <= cfg_wm1;
          mwd_pkg::RegFrameHeight: hm1_r        <= cfg_hm1;
          default: ;
        endcase
      end
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      frame_full_r <= full_nxt;

      if (s1_load) begin
        s1_valid_r  <= 1'b1;
        s1_emit_a_r <= is_flush || (i0 != '0 && c0 != '0);
        s1_emit_b_r <= !is_flush && i0 != '0 && row_end;
      end else if (s1_retire) begin
        s1_valid_r <= 1'b0;
      end else if (emit_go) begin
        // first of two results gone; hold for the row-end one
        s1_emit_a_r <= 1'b0;
      end

      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_gray_out   <= color_mode_r ? 8'd0 : med[7:0];
      out_red_out    <= color_mode_r ? med[23:16] : 8'd0;
      out_green_out  <= color_mode_r ? med[15:8] : 8'd0;
      out_blue_out   <= color_mode_r ? med[7:0] : 8'd0;
      out_frame_last <= s1_last_r;
    end
  end

`ifndef SYNTH
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with stage 1 empty");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= wm1_r)
    else $error("column counter beyond frame width");

  a_full_on_row0: assert property (@(posedge clk) disable iff (!rst_n)
    frame_full_r |-> row_r == '0)
    else $error("flush phase with nonzero row counter");

  a_flush_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_flush_r |-> !s1_emit_b_r && !s1_left_edge_r || !s1_emit_b_r)
    else $error("flush request scheduled a second result");

  a_last_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go && s1_last_r |-> s1_flush_r)
    else $error("frame end flagged on a pixel result");
`endif

endmodule

// ===== tb/sv/median_window_denoise_checker.sv =====
// ----------------------------------------------------------------------------
// median_window_denoise_checker: result predictor and scoreboard
// Watches the configuration port and the request and result channels,
// keeps its own copy of the line store and frame position, and compares
// every accepted result with the oldest predicted median, field by field.
// ----------------------------------------------------------------------------
module median_window_denoise_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [mwd_pkg::IdxW-1:0] cfg_index,
  input  logic [mwd_pkg::CfgW-1:0] cfg_wdata,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     in_cmd,
  input  logic [7:0]               in_gray_in,
  input  logic [7:0]               in_red_in,
  input  logic [7:0]               in_green_in,
  input  logic [7:0]               in_blue_in,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [7:0]               out_gray_out,
  input  logic [7:0]               out_red_out,
  input  logic [7:0]               out_green_out,
  input  logic [7:0]               out_blue_out,
  input  logic                     out_frame_last,
  output int                       fail_count,
  output int                       medians_due
);

  import mwd_pkg::*;

  localparam int Window = 3;
  localparam int Radius = (Window - 1) / 2;

  typedef struct packed {
    logic [7:0] gray;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } median_result_t;

  median_result_t expected_medians [$];

  pix_t        line_mem [Window][MaxWidth];
  logic        color_sel;
  logic [10:0] width_reg;
  logic [10:0] height_reg;
  int          col_pos;
  int          row_pos;
  int          flush_left;
  bit          flush_phase;
  int          mismatches;

  function automatic int eff_width();
    int w;
    w = int'(width_reg);
    if (w < 1) w = 1;
    if (w > MaxWidth) w = MaxWidth;
    return w;
  endfunction

  function automatic int eff_height();
    return (height_reg < 11'd1) ? 1 : int'(height_reg);
  endfunction

  function automatic int clamp_idx(int v, int limit);
    if (v < 0) return 0;
    if (v > limit - 1) return limit - 1;
    return v;
  endfunction

  function automatic logic [7:0] median_of_nine(logic [8:0][7:0] taps);
    logic [7:0] v [9];
    logic [7:0] x;
    int         i;
    int         j;
    for (i = 0; i < 9; i++) begin
      x = taps[i];
      j = i;
      while (j > 0 && v[j-1] > x) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = x;
    end
    return v[4];
  endfunction

  // Gather the clamped window around (r, c) and take per-channel medians
  function automatic median_result_t window_median(int r, int c, int w, int h, bit last);
    logic [8:0][7:0] red_t;
    logic [8:0][7:0] grn_t;
    logic [8:0][7:0] blu_t;
    pix_t            p;
    median_result_t  res;
    int              k;
    int              rr;
    int              cc;
    k = 0;
    for (int dy = -Radius; dy <= Radius; dy++) begin
      rr = clamp_idx(r + dy, h);
      for (int dx = -Radius; dx <= Radius; dx++) begin
        cc = clamp_idx(c + dx, w);
        p = line_mem[rr % Window][cc];
        red_t[k] = p[23:16];
        grn_t[k] = p[15:8];
        blu_t[k] = p[7:0];
        k++;
      end
    end
    res = '0;
    if (color_sel) begin
      res.red   = median_of_nine(red_t);
      res.green = median_of_nine(grn_t);
      res.blue  = median_of_nine(blu_t);
    end else begin
      res.gray  = median_of_nine(blu_t);
    end
    res.last = last;
    return res;
  endfunction

  task automatic restart_frame();
    col_pos     = 0;
    row_pos     = 0;
    flush_left  = 0;
    flush_phase = 1'b0;
  endtask

  task automatic apply_write(logic [IdxW-1:0] idx, logic [CfgW-1:0] data);
    case (idx)
      RegColorMode: begin
        color_sel = data[0];
        restart_frame();
      end
      RegFrameWidth: begin
        width_reg = data;
        restart_frame();
      end
      RegFrameHeight: begin
        height_reg = data;
        restart_frame();
      end
      default: ;
    endcase
  endtask

  task automatic absorb_request();
    int w;
    int h;
    int rows;
    int idx;
    int rr;
    int c;
    bit last;
    w    = eff_width();
    h    = eff_height();
    rows = (h < Radius) ? h : Radius;
    if (in_cmd == CmdFlush) begin
      // drop flushes outside the drain phase
      if (flush_phase && flush_left != 0) begin
        idx = rows * w - flush_left;
        rr  = h - rows + idx / w;
        flush_left--;
        last = (flush_left == 0);
        if (last) restart_frame();
        expected_medians.push_back(window_median(rr, idx % w, w, h, last));
      end
    end else begin
      if (flush_phase) restart_frame();
      c = col_pos;
      line_mem[row_pos % Window][c] = color_sel ? {in_red_in, in_green_in, in_blue_in}
                                                : {16'h0000, in_gray_in};
      if (row_pos >= Radius) begin
        rr = row_pos - Radius;
        if (c == w - 1) begin
          for (int cc = (c >= Radius) ? c - Radius : 0; cc <= c; cc++)
            expected_medians.push_back(window_median(rr, cc, w, h, 1'b0));
        end else if (c >= Radius) begin
          expected_medians.push_back(window_median(rr, c - Radius, w, h, 1'b0));
        end
      end
      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) begin
          row_pos     = 0;
          flush_phase = 1'b1;
          flush_left  = rows * w;
        end
      end
    end
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    median_result_t want;
    if (expected_medians.size() == 0) begin
      $display("%0t: unexpected result: expected none, got gray %h red %h green %h blue %h last %b",
               $time, out_gray_out, out_red_out, out_green_out, out_blue_out, out_frame_last);
      mismatches++;
    end else begin
      want = expected_medians.pop_front();
      check_field("gray", want.gray, out_gray_out);
      check_field("red", want.red, out_red_out);
      check_field("green", want.green, out_green_out);
      check_field("blue", want.blue, out_blue_out);
      check_field("frame_last", {7'd0, want.last}, {7'd0, out_frame_last});
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      color_sel  = 1'b0;
      width_reg  = 11'd256;
      height_reg = 11'd256;
      restart_frame();
      expected_medians.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) apply_write(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) absorb_request();
      if (out_valid && !out_stall) check_result();
    end
    medians_due <= expected_medians.size();
    fail_count  <= mismatches;
  end

endmodule

// ===== tb/sv/median_window_denoise_top_tb.sv =====
// ----------------------------------------------------------------------------
// median_window_denoise_top_tb: regression bench of the 3x3 median filter
// Drives directed and random frames in gray and color mode through the
// block under several idle and stall patterns; a checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module median_window_denoise_top_tb;

  import mwd_pkg::*;

  // Index with no register behind it; a write there must change nothing
  localparam logic [IdxW-1:0] RegUnused = 2'd3;

  localparam int HoldCycles  = 300;   // long receiver hold-off
  localparam int DrainCycles = 10;    // pipeline settle time
  localparam int IdleLimit   = 2000;  // cycles with no handshake at all

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [IdxW-1:0] cfg_index;
  logic [CfgW-1:0] cfg_wdata;
  logic            in_valid;
  logic            in_stall;
  logic            in_cmd;
  logic [7:0]      in_gray_in;
  logic [7:0]      in_red_in;
  logic [7:0]      in_green_in;
  logic [7:0]      in_blue_in;
  logic            out_valid;
  logic            out_stall;
  logic [7:0]      out_gray_out;
  logic [7:0]      out_red_out;
  logic [7:0]      out_green_out;
  logic [7:0]      out_blue_out;
  logic            out_frame_last;

  int fail_count;
  int medians_due;

  int send_idle_pct;
  int stall_pct;
  int hold_requests;
  int hold_seen;
  int hold_left;
  int quiet_cycles;

  median_window_denoise_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_gray_in    (in_gray_in),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_gray_out  (out_gray_out),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_frame_last(out_frame_last)
  );

  median_window_denoise_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_gray_in    (in_gray_in),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_gray_out  (out_gray_out),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_frame_last(out_frame_last),
    .fail_count    (fail_count),
    .medians_due   (medians_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls at stall_pct, plus a long hold-off whenever the
  // stimulus bumps hold_requests. Count the hold-off here, not in the sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_seen = 0;
      hold_left = 0;
    end else if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HoldCycles - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: end the run once nothing has moved for IdleLimit cycles
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("median_window_denoise_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mostly random bytes; ext_pct percent of the time pick 0 or 255
  function automatic logic [7:0] pick_sample(int ext_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < ext_pct / 2) return 8'h00;
    if (roll < ext_pct) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // Offer one request and hold it until accepted. Leave valid high on
  // return so back-to-back requests never drop valid in between.
  task automatic send_req(logic cmd, logic [7:0] g, logic [7:0] r, logic [7:0] gn,
                          logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_gray_in  <= g;
    in_red_in   <= r;
    in_green_in <= gn;
    in_blue_in  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_pixel(int ext_pct);
    send_req(CmdPixel, pick_sample(ext_pct), pick_sample(ext_pct), pick_sample(ext_pct),
             pick_sample(ext_pct));
  endtask

  // Flush payload is don't-care; randomize it anyway
  task automatic send_flush();
    send_req(CmdFlush, pick_sample(0), pick_sample(0), pick_sample(0), pick_sample(0));
  endtask

  // Drop valid, wait for every predicted result, then let the pipe settle
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (medians_due != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // One register write; the caller lowers cfg_we after the last one
  task automatic cfg_write(logic [IdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic set_frame(logic mode, int w, int h);
    drain_block();
    cfg_write(RegColorMode, CfgW'(mode));
    cfg_write(RegFrameWidth, CfgW'(w));
    cfg_write(RegFrameHeight, CfgW'(h));
    cfg_we <= 1'b0;
  endtask

  // Send a w x h frame (effective sizes), with stray flushes mixed in at
  // noise_pct, then drain it. A cut frame stops partway through the drain
  // so the next pixel or register write has to drop the rest.
  task automatic run_frame(int w, int h, int ext_pct, int noise_pct, bit cut);
    int flushes;
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(99) < noise_pct) send_flush();
      send_pixel(ext_pct);
    end
    flushes = cut ? $urandom_range(1, w - 1) : w + $urandom_range(2);
    repeat (flushes) send_flush();
  endtask

  initial begin
    int   fw;
    int   fh;
    logic mode;

    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_cmd        = CmdPixel;
    in_gray_in    = '0;
    in_red_in     = '0;
    in_green_in   = '0;
    in_blue_in    = '0;
    out_stall     = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_requests = 0;
    quiet_cycles  = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Out of reset: flushes with nothing pending, a few row 0 pixels in the
    // default 256 x 256 frame (no results), and a flush in mid-frame.
    send_flush();
    send_flush();
    repeat (3) send_pixel(100);
    send_flush();

    // Small frames, gray then color, samples mostly at the extremes
    set_frame(1'b0, 3, 3);
    run_frame(3, 3, 80, 20, 1'b0);
    set_frame(1'b1, 2, 2);
    run_frame(2, 2, 80, 20, 1'b0);

    // Pixel during the drain phase starts a new frame
    set_frame(1'b1, 4, 2);
    run_frame(4, 2, 50, 0, 1'b1);
    run_frame(4, 2, 50, 0, 1'b0);

    // Register write during the drain phase drops what is left
    set_frame(1'b0, 3, 2);
    run_frame(3, 2, 50, 0, 1'b1);

    // Write to an unused index mid-frame: the frame must carry on
    set_frame(1'b0, 4, 3);
    repeat (6) send_pixel(30);
    drain_block();
    cfg_write(RegUnused, CfgW'($urandom_range(2047)));
    cfg_we <= 1'b0;
    repeat (6) send_pixel(30);
    repeat (5) send_flush();

    // Size extremes: widest, 1024 tall, zero width, oversize width, zero height
    set_frame(1'b0, MaxWidth, 2);
    run_frame(MaxWidth, 2, 20, 0, 1'b0);
    set_frame(1'b1, 2, 1024);
    run_frame(2, 1024, 20, 0, 1'b0);
    set_frame(1'b0, 0, 5);
    run_frame(1, 5, 50, 10, 1'b0);
    set_frame(1'b1, 2047, 0);
    run_frame(MaxWidth, 1, 20, 0, 1'b0);

    // Random frames under four idle patterns
    fw = 2;
    fh = 2;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 71; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 71; end
        default: begin send_idle_pct = 35; stall_pct <= 35; end
      endcase
      for (int f = 0; f < 3; f++) begin
        if (f == 0 || $urandom_range(3) != 0) begin
          mode = 1'($urandom_range(1));
          fw   = $urandom_range(2, 8);
          fh   = $urandom_range(2, 5);
          if (phase == 0 && f == 0) begin
            // hold off the receiver while a full frame streams in
            fw = 8;
            fh = 5;
          end
          set_frame(mode, fw, fh);
        end
        if (phase == 0 && f == 0) hold_requests <= hold_requests + 1;
        run_frame(fw, fh, 15, 5, ($urandom_range(99) < 15));
      end
    end

    drain_block();
    if (fail_count == 0 && medians_due == 0) begin
      $display("median_window_denoise_top regression: pass");
    end else begin
      $display("median_window_denoise_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mwd_pkg.sv
rtl/core/mwd_median.sv
rtl/core/median_window_denoise_top.sv
tb/sv/median_window_denoise_checker.sv
tb/sv/median_window_denoise_top_tb.sv
